@@ design/ssf_pkg.sv @@
// Shared types, constants and the sample scaling function of the scope sample framer.
// No dependencies; every other file of the block imports this package.
package ssf_pkg;

  localparam int FRAME_LEN     = 20;
  localparam int SLOT_W        = 5;
  localparam int CHANNELS      = 4;
  localparam int PER_CHAN_QUAD = 5;
  localparam int PER_CHAN_DUAL = 10;
  localparam int SAMPLE_W      = 16;
  localparam int RAW_W         = 32;
  localparam int SHIFT_W       = 4;
  localparam int SHIFT_MAX     = 14;
  localparam int SLOW_W        = 32;
  localparam int SLOW_ID_W     = 4;
  localparam int COUNT_W       = 4;
  localparam int QUEUE_DEPTH   = 2;
  localparam int CFG_ADDR_W    = 3;
  localparam int CFG_DATA_W    = 4;
  localparam int IN_TDATA_W    = 168;
  localparam int OUT_TDATA_W   = 64;

  localparam int SLOW_ENTRIES_DEFAULT = 16;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_CHANNEL_MODE = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SHIFT_FIRST  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SHIFT_SECOND = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SHIFT_THIRD  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_SHIFT_FOURTH = 3'd4;

  // Input operation codes
  localparam logic OP_SAMPLE     = 1'b0;
  localparam logic OP_SLOW_WRITE = 1'b1;

  // Channel mode codes
  localparam logic MODE_QUAD = 1'b0;
  localparam logic MODE_DUAL = 1'b1;

  // One classified command, passed from the front end to the back end
  typedef struct packed {
    logic                                is_slow;
    logic                                wr_samples;
    logic                                emit;
    logic                                mode;
    logic [COUNT_W-1:0]                  count;
    logic [CHANNELS-1:0][SAMPLE_W-1:0]   val;
    logic [SLOW_ID_W-1:0]                slow_idx;
    logic [SLOW_W-1:0]                   slow_val;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Scale Q16.16 by 2^shift, truncate toward zero, saturate to int16
  function automatic logic [SAMPLE_W-1:0] scale_sample(input logic [RAW_W-1:0] raw,
                                                       input logic [SHIFT_W-1:0] shift);
    logic                   neg;
    logic [RAW_W-1:0]       mag;
    logic [SHIFT_W-1:0]     sh;
    logic [RAW_W+13:0]      prod;
    logic [RAW_W-3:0]       q;
    logic [SAMPLE_W-1:0]    res;
    neg  = raw[RAW_W-1];
    mag  = neg ? (~raw + 32'd1) : raw;
    sh   = (shift > SHIFT_W'(SHIFT_MAX)) ? SHIFT_W'(SHIFT_MAX) : shift;
    prod = (RAW_W+14)'(mag) << sh;
    q    = prod[RAW_W+13:16];
    if (neg) begin
      res = (q >= 30'd32768) ? 16'h8000 : 16'(~q + 30'd1);
    end else begin
      res = (q > 30'd32767) ? 16'h7FFF : q[SAMPLE_W-1:0];
    end
    return res;
  endfunction

endpackage

@@ design/ssf_front.sv @@
// Front end of the scope sample framer: configuration registers, sample count,
// scaling and classification of input items into commands. Depends on ssf_pkg.
module ssf_front import ssf_pkg::*; (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [CFG_ADDR_W-1:0]             cfg_addr,
  input  logic [CFG_DATA_W-1:0]             cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_op,
  input  logic [CHANNELS-1:0][RAW_W-1:0]    in_samples,
  input  logic [SLOW_ID_W-1:0]              in_slow_index,
  input  logic [SLOW_W-1:0]                 in_slow_value,
  input  q_status_t                         q_stat,
  output logic                              push,
  output cmd_t                              push_cmd
);

  logic                              mode_r, mode_nxt;
  logic [CHANNELS-1:0][SHIFT_W-1:0]  shift_r, shift_nxt;
  logic [COUNT_W-1:0]                count_r, count_nxt;
  logic [COUNT_W-1:0]                per_chan;
  logic [COUNT_W-1:0]                cnt_inc;
  logic                              emit;

  assign in_ready = !q_stat.full;
  assign push     = in_valid && in_ready;

  assign per_chan = (mode_r == MODE_DUAL) ? COUNT_W'(PER_CHAN_DUAL) : COUNT_W'(PER_CHAN_QUAD);
  assign cnt_inc  = count_r + COUNT_W'(1);
  assign emit     = (cnt_inc >= per_chan);

  always_comb begin
    push_cmd            = '0;
    push_cmd.is_slow    = (in_op == OP_SLOW_WRITE);
    push_cmd.wr_samples = (count_r < per_chan);
    push_cmd.emit       = emit;
    push_cmd.mode       = mode_r;
    push_cmd.count      = count_r;
    for (int c = 0; c < CHANNELS; c++) begin
      push_cmd.val[c] = scale_sample(in_samples[c], shift_r[c]);
    end
    push_cmd.slow_idx   = in_slow_index;
    push_cmd.slow_val   = in_slow_value;
  end

  always_comb begin
    count_nxt = count_r;
    if (push && in_op == OP_SAMPLE) begin
      count_nxt = emit ? '0 : cnt_inc;
    end
  end

  always_comb begin
    mode_nxt  = mode_r;
    shift_nxt = shift_r;
    if (cfg_we) begin
      case (cfg_addr)
        REG_CHANNEL_MODE: mode_nxt     = cfg_wdata[0];
        REG_SHIFT_FIRST:  shift_nxt[0] = cfg_wdata;
        REG_SHIFT_SECOND: shift_nxt[1] = cfg_wdata;
        REG_SHIFT_THIRD:  shift_nxt[2] = cfg_wdata;
        REG_SHIFT_FOURTH: shift_nxt[3] = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_QUAD;
      shift_r <= '0;
      count_r <= '0;
    end else begin
      mode_r  <= mode_nxt;
      shift_r <= shift_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

@@ design/ssf_queue.sv @@
// Short command queue between front and back end of the scope sample framer.
// Depends on ssf_pkg for the command type and depth.
module ssf_queue import ssf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  cmd_t       push_cmd,
  input  logic       pop,
  output cmd_t       pop_cmd,
  output q_status_t  q_stat
);

  localparam int QA = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  cmd_t            q_mem_r [QUEUE_DEPTH];
  logic [QA-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QA-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QA:0]     cnt_r, cnt_nxt;

  assign q_stat.full  = (cnt_r == (QA+1)'(QUEUE_DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign pop_cmd      = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QA'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_r + QA'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QA'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_r + QA'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + (QA+1)'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - (QA+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

@@ design/ssf_back.sv @@
// Back end of the scope sample framer: frame buffer, slow-data store and frame drain
// through the output register. Depends on ssf_pkg.
module ssf_back import ssf_pkg::*; #(
  parameter int SLOW_ENTRIES = SLOW_ENTRIES_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  q_status_t             q_stat,
  input  cmd_t                  pop_cmd,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SAMPLE_W-1:0]   out_value,
  output logic [SLOT_W-1:0]     out_slot,
  output logic [SLOW_W-1:0]     out_slow_word,
  output logic [SLOW_ID_W-1:0]  out_slow_id,
  output logic                  out_last
);

  localparam int AW = (SLOW_ENTRIES > 1) ? $clog2(SLOW_ENTRIES) : 1;

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic                  state_r, state_nxt;
  logic [SLOT_W-1:0]     k_r, k_nxt;
  logic [AW-1:0]         ptr_r, ptr_nxt;
  logic                  load;
  logic                  k_last;

  logic [SAMPLE_W-1:0]   frame_buf_r [FRAME_LEN];

  logic [SLOW_W-1:0]     slow_mem [SLOW_ENTRIES];
  logic                  slow_vld_r [SLOW_ENTRIES];
  logic [SLOW_W-1:0]     slow_rd_r;
  logic                  slow_rd_vld_r;
  logic                  slow_we;
  logic [AW-1:0]         slow_waddr;

  logic                  out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0]   out_value_r;
  logic [SLOT_W-1:0]     out_slot_r;
  logic [SLOW_W-1:0]     out_slow_word_r;
  logic [SLOW_ID_W-1:0]  out_slow_id_r;
  logic                  out_last_r;

  assign pop    = (state_r == ST_IDLE) && !q_stat.empty;
  assign load   = (state_r == ST_DRAIN) && (!out_valid_r || out_ready);
  assign k_last = (k_r == SLOT_W'(FRAME_LEN-1));

  // Frame buffer: each slot decodes its own channel and sample position per mode
  for (genvar j = 0; j < FRAME_LEN; j++) begin : g_slot
    localparam int QC = j / PER_CHAN_QUAD;
    localparam int QS = j % PER_CHAN_QUAD;
    localparam int DC = j / PER_CHAN_DUAL;
    localparam int DS = j % PER_CHAN_DUAL;
    logic hit;
    logic [SAMPLE_W-1:0] wval;
    always_comb begin
      hit  = 1'b0;
      wval = pop_cmd.val[QC];
      if (pop && !pop_cmd.is_slow && pop_cmd.wr_samples) begin
        if (pop_cmd.mode == MODE_DUAL) begin
          hit  = (pop_cmd.count == COUNT_W'(DS));
        end else begin
          hit  = (pop_cmd.count == COUNT_W'(QS));
        end
      end
      if (pop_cmd.mode == MODE_DUAL) begin
        wval = pop_cmd.val[DC];
      end
    end
    always_ff @(posedge clk) begin
      if (hit) begin
        frame_buf_r[j] <= wval;
      end
    end
  end

  // Slow-data store: drop writes beyond the store
  assign slow_we    = pop && pop_cmd.is_slow && (32'(pop_cmd.slow_idx) < SLOW_ENTRIES);
  assign slow_waddr = AW'(pop_cmd.slow_idx);

  always_ff @(posedge clk) begin
    if (slow_we) begin
      slow_mem[slow_waddr] <= pop_cmd.slow_val;
    end
  end

  always_ff @(posedge clk) begin
    slow_rd_r <= slow_mem[ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int e = 0; e < SLOW_ENTRIES; e++) begin
        slow_vld_r[e] <= 1'b0;
      end
      slow_rd_vld_r <= 1'b0;
    end else begin
      if (slow_we) begin
        slow_vld_r[slow_waddr] <= 1'b1;
      end
      slow_rd_vld_r <= slow_vld_r[ptr_r];
    end
  end

  // Sequencer: pop commands while idle, drain the frame after an emitting tick
  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    ptr_nxt   = ptr_r;
    case (state_r)
      ST_IDLE: begin
        if (pop && !pop_cmd.is_slow && pop_cmd.emit) begin
          state_nxt = ST_DRAIN;
          k_nxt     = '0;
        end
      end
      ST_DRAIN: begin
        if (load) begin
          k_nxt = k_r + SLOT_W'(1);
          if (k_last) begin
            state_nxt = ST_IDLE;
            ptr_nxt   = (ptr_r == AW'(SLOW_ENTRIES-1)) ? '0 : ptr_r + AW'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_value_r     <= frame_buf_r[k_r];
      out_slot_r      <= k_r;
      out_last_r      <= k_last;
      out_slow_word_r <= (k_last && slow_rd_vld_r) ? slow_rd_r : '0;
      out_slow_id_r   <= k_last ? SLOW_ID_W'(ptr_r) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= '0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_value     = out_value_r;
  assign out_slot      = out_slot_r;
  assign out_slow_word = out_slow_word_r;
  assign out_slow_id   = out_slow_id_r;
  assign out_last      = out_last_r;

endmodule

@@ design/scope_sample_framer_unit.sv @@
// Top level of the scope sample framer: stream ports, front end, command queue and back end.
// Depends on ssf_pkg, ssf_front, ssf_queue and ssf_back.
//
// Oscilloscope capture framer. Each transfer on the input stream is either a sample
// tick (in_tuser = 0) carrying four signed Q16.16 channel values, or a slow-data store
// write (in_tuser = 1). The front end scales each used channel by 2^shift (shift clamped
// to 14), truncates toward zero and saturates to int16, then queues the tick; it accepts
// one transfer per cycle while the two-entry queue has room. The back end takes one
// queued command per cycle, when not draining, into the frame buffer or the slow-data
// store. After the fifth tick (four-channel mode) or the tenth (two-channel mode) it drains
// the 20 frame slots in slot order, one per cycle as the output side takes them; only the
// last transfer of a frame (out_tlast) carries the round-robin slow-data word and its
// index, zero elsewhere. Sustained throughput is thus set by the one-slot-per-cycle drain.
// The input side keeps accepting until the queue fills during a drain. The slow-data
// store reads as zero until written (per-entry valid bits, no clearing pass). Write
// configuration only while the block is idle.
module scope_sample_framer_unit import ssf_pkg::*; #(
  parameter int SLOW_ENTRIES = SLOW_ENTRIES_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  // sample_first, sample_second, sample_third, sample_fourth, slow_index, slow_value, pad
  input  logic [IN_TDATA_W-1:0]   in_tdata,
  // op
  input  logic                    in_tuser,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  // sample_value, slot, slow_word, slow_id, pad
  output logic [OUT_TDATA_W-1:0]  out_tdata,
  output logic                    out_tlast
);

  logic [CHANNELS-1:0][RAW_W-1:0]  samples;
  logic [SLOW_ID_W-1:0]            slow_index;
  logic [SLOW_W-1:0]               slow_value;

  q_status_t                       q_stat;
  logic                            push;
  cmd_t                            push_cmd;
  logic                            pop;
  cmd_t                            pop_cmd;

  logic [SAMPLE_W-1:0]             out_value;
  logic [SLOT_W-1:0]               out_slot;
  logic [SLOW_W-1:0]               out_slow_word;
  logic [SLOW_ID_W-1:0]            out_slow_id;

  // Unpack the input transfer, lowest field first
  assign samples[0] = in_tdata[31:0];
  assign samples[1] = in_tdata[63:32];
  assign samples[2] = in_tdata[95:64];
  assign samples[3] = in_tdata[127:96];
  assign slow_index = in_tdata[131:128];
  assign slow_value = in_tdata[163:132];

  ssf_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .in_op         (in_tuser),
    .in_samples    (samples),
    .in_slow_index (slow_index),
    .in_slow_value (slow_value),
    .q_stat        (q_stat),
    .push          (push),
    .push_cmd      (push_cmd)
  );

  // Decouple classification from the frame drain
  ssf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .q_stat   (q_stat)
  );

  ssf_back #(
    .SLOW_ENTRIES (SLOW_ENTRIES)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_stat        (q_stat),
    .pop_cmd       (pop_cmd),
    .pop           (pop),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_value     (out_value),
    .out_slot      (out_slot),
    .out_slow_word (out_slow_word),
    .out_slow_id   (out_slow_id),
    .out_last      (out_tlast)
  );

  // Pack the result transfer, lowest field first, zero pad to whole bytes
  assign out_tdata = {7'd0, out_slow_id, out_slow_word, out_slot, out_value};

  // The last transfer of a frame sits in the final slot
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_slot == SLOT_W'(FRAME_LEN-1))
    else $error("frame end flagged away from final slot");

  // Slow-data fields stay zero except on the last transfer of a frame
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_slow_word == '0 && out_slow_id == '0)
    else $error("slow-data fields set inside a frame");

  // Within a frame the drain presents the next slot right after each transfer
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=>
      out_tvalid && out_slot == $past(out_slot) + SLOT_W'(1))
    else $error("frame drain skipped or stalled a slot");

endmodule
